// ===== hw/rtl/contour_segment_chainer_macros.svh =====
// Assertion macros for the contour segment chainer
`ifndef CONTOUR_SEGMENT_CHAINER_MACROS_SVH
`define CONTOUR_SEGMENT_CHAINER_MACROS_SVH

`define CSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("contour segment chainer check failed");

`define CSC_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("contour segment chainer implication failed");

`endif

// ===== hw/rtl/csc_pkg.sv =====
// Types, constants and codes shared by the contour segment chainer
package csc_pkg;

  localparam int unsigned MAX_SEGS_DEF = 64;
  localparam int unsigned MAX_RESULTS  = 64;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned HEAD_W       = 25;
  localparam int unsigned OUT_IDX_W    = 6;
  localparam int unsigned TOL_W        = 16;

  localparam logic [TOL_W-1:0]  TOL_RESET = 16'd20;
  localparam logic [HEAD_W-1:0] HEAD_HALF = 25'(180 * 65536);
  localparam logic [HEAD_W-1:0] HEAD_FULL = 25'(360 * 65536);

  typedef enum logic [1:0] {
    KIND_LINE   = 2'd0,
    KIND_ARC    = 2'd1,
    KIND_CIRCLE = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_START = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_FOUND,
    S_CRD,
    S_CCMP,
    S_CFOUND,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic               req_type;
    logic [1:0]         seg_kind;
    logic               seg_cw;
    logic signed [31:0] seg_x1;
    logic signed [31:0] seg_y1;
    logic signed [31:0] seg_x2;
    logic signed [31:0] seg_y2;
    logic [24:0]        seg_heading;
    logic signed [31:0] seg_angle_a;
    logic signed [31:0] seg_angle_b;
    logic [31:0]        seg_length;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         out_index;
    logic [1:0]         out_kind;
    logic               out_cw;
    logic signed [31:0] out_x1;
    logic signed [31:0] out_y1;
    logic signed [31:0] out_x2;
    logic signed [31:0] out_y2;
    logic [24:0]        out_heading;
    logic signed [31:0] out_angle_a;
    logic signed [31:0] out_angle_b;
    logic [31:0]        out_length;
    logic               out_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               cw;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic [24:0]        heading;
    logic signed [31:0] angle_a;
    logic signed [31:0] angle_b;
    logic [31:0]        length;
  } entry_t;

  typedef struct packed {
    logic load;
    logic start;
    logic idx_inc;
    logic pass_end;
    logic rescan;
    logic take;
    logic flush;
    logic clr_count;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    logic hit;
    logic circ_hit;
    logic out_free;
    logic pend_valid;
    logic pass_end;
  } sts_t;

endpackage

// ===== hw/rtl/contour_segment_chainer.sv =====
// Top level of the contour segment chainer
// A load returns no result; loads stream one per cycle.
// A start walks the store: each search pass reads every stored entry
// (registered store read, then compare), up to two passes per chain link, plus
// one circle sweep over the stored entries when a chain was found.
// Reset clears the segment count, the tolerance (to 20) and all handshake state.
`include "contour_segment_chainer_macros.svh"
module contour_segment_chainer #(
  parameter int unsigned MaxSegs = csc_pkg::MAX_SEGS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [csc_pkg::TOL_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  csc_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output csc_pkg::out_item_t         out_data_o
);

  csc_pkg::cmd_t cmd;
  csc_pkg::sts_t sts;
  logic busy;

  csc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  csc_dpath #(
    .MaxSegs (MaxSegs)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = busy;

  `CSC_ASSERT(a_out_only_when_busy, $rose(out_valid_o) |-> $past(in_stall_o))
  `CSC_ASSERT_IMPL(a_idle_no_pending, !in_stall_o, !sts.pend_valid)
  `CSC_ASSERT_IMPL(a_idle_first_pass, !in_stall_o && $past(in_stall_o), !cmd.take)

endmodule

// ===== hw/rtl/csc_ctrl.sv =====
// Sequencer for load, chain search, circle sweep and final flush
module csc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            req_type_i,
  input  csc_pkg::sts_t   sts_i,
  output csc_pkg::cmd_t   cmd_o,
  output logic            busy_o
);

  csc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      csc_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (in_valid_i) begin
          if (req_type_i == csc_pkg::REQ_START) begin
            cmd_o.start = 1'b1;
            state_d     = csc_pkg::S_RD;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      csc_pkg::S_RD: begin
        if (!sts_i.at_end) begin
          state_d = csc_pkg::S_CMP;
        end else if (!sts_i.pass_end) begin
          cmd_o.pass_end = 1'b1;
        end else if (sts_i.pend_valid) begin
          cmd_o.rescan = 1'b1;
          state_d      = csc_pkg::S_CRD;
        end else begin
          cmd_o.clr_count = 1'b1;
          state_d         = csc_pkg::S_IDLE;
        end
      end
      csc_pkg::S_CMP: begin
        if (sts_i.hit) begin
          state_d = csc_pkg::S_FOUND;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = csc_pkg::S_RD;
        end
      end
      csc_pkg::S_FOUND: begin
        if (sts_i.out_free) begin
          cmd_o.take   = 1'b1;
          cmd_o.rescan = 1'b1;
          state_d      = csc_pkg::S_RD;
        end
      end
      csc_pkg::S_CRD: begin
        state_d = sts_i.at_end ? csc_pkg::S_FLUSH : csc_pkg::S_CCMP;
      end
      csc_pkg::S_CCMP: begin
        if (sts_i.circ_hit) begin
          state_d = csc_pkg::S_CFOUND;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = csc_pkg::S_CRD;
        end
      end
      csc_pkg::S_CFOUND: begin
        if (sts_i.out_free) begin
          cmd_o.take    = 1'b1;
          cmd_o.idx_inc = 1'b1;
          state_d       = csc_pkg::S_CRD;
        end
      end
      csc_pkg::S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush     = 1'b1;
          cmd_o.clr_count = 1'b1;
          state_d         = csc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = csc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/csc_dpath.sv =====
// Segment store, point compare, orientation and result registers
module csc_dpath #(
  parameter int unsigned MaxSegs = csc_pkg::MAX_SEGS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [csc_pkg::TOL_W-1:0]   cfg_wdata_i,
  input  csc_pkg::in_item_t           in_data_i,
  input  logic                        out_stall_i,
  input  csc_pkg::cmd_t               cmd_i,
  output csc_pkg::sts_t               sts_o,
  output logic                        out_valid_o,
  output csc_pkg::out_item_t          out_data_o
);

  localparam int unsigned IdxW = (MaxSegs > 1) ? $clog2(MaxSegs) : 1;
  localparam int unsigned CntW = $clog2(MaxSegs + 1);
  localparam int unsigned ResW = $clog2(csc_pkg::MAX_RESULTS + 1);

  csc_pkg::entry_t mem [MaxSegs];
  csc_pkg::entry_t rdata_q;
  logic [MaxSegs-1:0] used_q;
  logic [CntW-1:0] count_q, idx_q;
  logic [ResW-1:0] res_cnt_q;
  logic pass_q;
  logic [csc_pkg::TOL_W-1:0] tol_q;
  logic signed [31:0] px_q, py_q;
  csc_pkg::out_item_t pend_q, out_q, fresh;
  logic pend_valid_q, out_valid_q;
  logic [IdxW-1:0] addr;
  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic signed [31:0] cx, cy;
  logic chainable, near, full;

  assign addr = idx_q[IdxW-1:0];
  assign full = (count_q == CntW'(MaxSegs));

  always_comb begin
    cx  = pass_q ? rdata_q.x2 : rdata_q.x1;
    cy  = pass_q ? rdata_q.y2 : rdata_q.y1;
    dx  = 33'(px_q) - 33'(cx);
    dy  = 33'(py_q) - 33'(cy);
    adx = dx[32] ? 33'(-dx) : 33'(dx);
    ady = dy[32] ? 33'(-dy) : 33'(dy);
    near = (adx <= 33'(tol_q)) && (ady <= 33'(tol_q));
    chainable = !used_q[addr] && ((rdata_q.kind == csc_pkg::KIND_LINE) ||
                                  (rdata_q.kind == csc_pkg::KIND_ARC));
  end

  always_comb begin
    fresh.out_index   = csc_pkg::OUT_IDX_W'(idx_q);
    fresh.out_kind    = rdata_q.kind;
    fresh.out_length  = rdata_q.length;
    fresh.out_last    = 1'b0;
    if (pass_q) begin
      fresh.out_cw      = ~rdata_q.cw;
      fresh.out_x1      = rdata_q.x2;
      fresh.out_y1      = rdata_q.y2;
      fresh.out_x2      = rdata_q.x1;
      fresh.out_y2      = rdata_q.y1;
      fresh.out_angle_a = rdata_q.angle_b;
      fresh.out_angle_b = rdata_q.angle_a;
      fresh.out_heading = (rdata_q.heading >= csc_pkg::HEAD_HALF) ?
                          rdata_q.heading - csc_pkg::HEAD_HALF :
                          rdata_q.heading + csc_pkg::HEAD_HALF;
    end else begin
      fresh.out_cw      = rdata_q.cw;
      fresh.out_x1      = rdata_q.x1;
      fresh.out_y1      = rdata_q.y1;
      fresh.out_x2      = rdata_q.x2;
      fresh.out_y2      = rdata_q.y2;
      fresh.out_angle_a = rdata_q.angle_a;
      fresh.out_angle_b = rdata_q.angle_b;
      fresh.out_heading = rdata_q.heading;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem[count_q[IdxW-1:0]] <= '{kind: in_data_i.seg_kind, cw: in_data_i.seg_cw,
                                  x1: in_data_i.seg_x1, y1: in_data_i.seg_y1,
                                  x2: in_data_i.seg_x2, y2: in_data_i.seg_y2,
                                  heading: in_data_i.seg_heading,
                                  angle_a: in_data_i.seg_angle_a,
                                  angle_b: in_data_i.seg_angle_b,
                                  length: in_data_i.seg_length};
    end
    rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      used_q[count_q[IdxW-1:0]] <= 1'b0;
    end else if (cmd_i.take) begin
      used_q[addr] <= 1'b1;
    end
    if (cmd_i.start) begin
      px_q <= in_data_i.seg_x1;
      py_q <= in_data_i.seg_y1;
    end else if (cmd_i.take) begin
      px_q <= pass_q ? rdata_q.x1 : rdata_q.x2;
      py_q <= pass_q ? rdata_q.y1 : rdata_q.y2;
    end
    if (cmd_i.take && (res_cnt_q < ResW'(csc_pkg::MAX_RESULTS))) begin
      pend_q <= fresh;
    end
    if (cmd_i.flush) begin
      out_q          <= pend_q;
      out_q.out_last <= 1'b1;
    end else if (cmd_i.take && pend_valid_q &&
                 (res_cnt_q < ResW'(csc_pkg::MAX_RESULTS))) begin
      out_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      idx_q        <= '0;
      res_cnt_q    <= '0;
      pass_q       <= 1'b0;
      tol_q        <= csc_pkg::TOL_RESET;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_count) begin
        count_q <= '0;
      end else if (cmd_i.load && !full) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.start || cmd_i.rescan) begin
        idx_q  <= '0;
        pass_q <= 1'b0;
      end else if (cmd_i.pass_end) begin
        idx_q  <= '0;
        pass_q <= 1'b1;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.start) begin
        res_cnt_q <= '0;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.take && (res_cnt_q < ResW'(csc_pkg::MAX_RESULTS))) begin
        res_cnt_q    <= res_cnt_q + 1'b1;
        pend_valid_q <= 1'b1;
        if (pend_valid_q) begin
          out_valid_q <= 1'b1;
        end
      end
      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end
    end
  end

  assign sts_o.at_end     = (idx_q == count_q);
  assign sts_o.hit        = chainable && near;
  assign sts_o.circ_hit   = !used_q[addr] && (rdata_q.kind == csc_pkg::KIND_CIRCLE);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.pass_end   = pass_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/contour_segment_chainer_test.sv =====
// Testbench for the contour segment chainer: random chains checked against a predictor
module contour_segment_chainer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import csc_pkg::*;

  class chain_scoreboard;
    entry_t            seg_store[64];
    bit                seg_used[64];
    int                seg_count;
    logic [15:0]       tol;
    out_item_t         pending[$];
    int                errors;

    function new();
      seg_count = 0;
      tol = TOL_RESET;
      errors = 0;
    endfunction

    function bit near(logic signed [31:0] ax, logic signed [31:0] ay,
                      logic signed [31:0] bx, logic signed [31:0] by);
      longint dx;
      longint dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return dx <= longint'(tol) && dy <= longint'(tol);
    endfunction

    function bit linkable(int k);
      return !seg_used[k] && (seg_store[k].kind == KIND_LINE || seg_store[k].kind == KIND_ARC);
    endfunction

    function int find_link(logic [31:0] x, logic [31:0] y, output bit rev);
      rev = 1'b0;
      for (int k = 0; k < seg_count; k++)
        if (linkable(k) && near(x, y, seg_store[k].x1, seg_store[k].y1)) return k;
      rev = 1'b1;
      for (int k = 0; k < seg_count; k++)
        if (linkable(k) && near(x, y, seg_store[k].x2, seg_store[k].y2)) return k;
      return -1;
    endfunction

    function out_item_t oriented(int k, bit rev);
      out_item_t o;
      entry_t e;
      longint h;
      e = seg_store[k];
      h = longint'(e.heading);
      o.out_index = k[5:0];
      o.out_kind = e.kind;
      o.out_length = e.length;
      o.out_last = 1'b0;
      if (rev) begin
        h = h - (longint'(180) << 16);
        if (h < 0) h = h + (longint'(360) << 16);
        o.out_cw = ~e.cw;
        o.out_x1 = e.x2;
        o.out_y1 = e.y2;
        o.out_x2 = e.x1;
        o.out_y2 = e.y1;
        o.out_angle_a = e.angle_b;
        o.out_angle_b = e.angle_a;
      end else begin
        o.out_cw = e.cw;
        o.out_x1 = e.x1;
        o.out_y1 = e.y1;
        o.out_x2 = e.x2;
        o.out_y2 = e.y2;
        o.out_angle_a = e.angle_a;
        o.out_angle_b = e.angle_b;
      end
      o.out_heading = h[24:0];
      return o;
    endfunction

    function void note_input(in_item_t it);
      out_item_t chain[$];
      logic [31:0] px;
      logic [31:0] py;
      int m;
      bit rev;
      if (it.req_type == REQ_LOAD) begin
        if (seg_count < 64) begin
          seg_store[seg_count] = '{it.seg_kind, it.seg_cw, it.seg_x1, it.seg_y1, it.seg_x2,
                                   it.seg_y2, it.seg_heading, it.seg_angle_a,
                                   it.seg_angle_b, it.seg_length};
          seg_used[seg_count] = 1'b0;
          seg_count++;
        end
        return;
      end
      px = it.seg_x1;
      py = it.seg_y1;
      m = find_link(px, py, rev);
      while (m >= 0) begin
        seg_used[m] = 1'b1;
        if (chain.size() < MAX_RESULTS) chain.push_back(oriented(m, rev));
        px = rev ? seg_store[m].x1 : seg_store[m].x2;
        py = rev ? seg_store[m].y1 : seg_store[m].y2;
        m = find_link(px, py, rev);
      end
      if (chain.size() > 0) begin
        for (int k = 0; k < seg_count; k++)
          if (seg_store[k].kind == KIND_CIRCLE && !seg_used[k] && chain.size() < MAX_RESULTS)
            chain.push_back(oriented(k, 1'b0));
        chain[chain.size()-1].out_last = 1'b1;
      end
      foreach (chain[i]) pending.push_back(chain[i]);
      seg_count = 0;
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s expected %h actual %h", $realtime, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      field("out_index", e.out_index, got.out_index);
      field("out_kind", e.out_kind, got.out_kind);
      field("out_cw", e.out_cw, got.out_cw);
      field("out_x1", e.out_x1, got.out_x1);
      field("out_y1", e.out_y1, got.out_y1);
      field("out_x2", e.out_x2, got.out_x2);
      field("out_y2", e.out_y2, got.out_y2);
      field("out_heading", e.out_heading, got.out_heading);
      field("out_angle_a", e.out_angle_a, got.out_angle_a);
      field("out_angle_b", e.out_angle_b, got.out_angle_b);
      field("out_length", e.out_length, got.out_length);
      field("out_last", e.out_last, got.out_last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  chain_scoreboard sb = new();
  bit quiet = 1'b0;
  int sent = 0;
  int stall_left = 0;

  contour_segment_chainer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        stall_left = quiet ? 0 : $urandom_range(0, 10);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push(in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  task automatic set_tolerance(logic [15:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.tol = v;
  endtask

  function automatic in_item_t make_seg(kind_e k, logic [31:0] x1, logic [31:0] y1,
                                        logic [31:0] x2, logic [31:0] y2);
    in_item_t it;
    it.req_type = REQ_LOAD;
    it.seg_kind = k;
    it.seg_cw = 1'($urandom_range(0, 1));
    it.seg_x1 = x1;
    it.seg_y1 = y1;
    it.seg_x2 = x2;
    it.seg_y2 = y2;
    it.seg_heading = ($urandom_range(0, 7) == 0) ? 25'($urandom) :
                                                   25'($urandom_range(0, 23592959));
    it.seg_angle_a = $urandom;
    it.seg_angle_b = $urandom;
    it.seg_length = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_start(logic [31:0] x, logic [31:0] y);
    in_item_t it;
    it = make_seg(kind_e'($urandom_range(0, 3)), x, y, $urandom, $urandom);
    it.req_type = REQ_START;
    return it;
  endfunction

  task automatic chain_phase(int n);
    logic [31:0] px[$];
    logic [31:0] py[$];
    in_item_t segs[$];
    in_item_t tmp;
    logic [31:0] jit;
    int j;
    for (int i = 0; i <= n; i++) begin
      px.push_back($urandom);
      py.push_back($urandom);
    end
    for (int i = 0; i < n; i++) begin
      jit = (sb.tol >= 3) ? $urandom_range(0, 3) : 0;
      if ($urandom_range(0, 1))
        segs.push_back(make_seg($urandom_range(0, 1) ? KIND_ARC : KIND_LINE,
                                px[i] + jit, py[i], px[i+1], py[i+1]));
      else
        segs.push_back(make_seg($urandom_range(0, 1) ? KIND_ARC : KIND_LINE,
                                px[i+1], py[i+1], px[i] + jit, py[i]));
    end
    if ($urandom_range(0, 1)) segs.push_back(make_seg(KIND_CIRCLE, $urandom, $urandom,
                                                      $urandom, $urandom));
    if ($urandom_range(0, 3) == 0) segs.push_back(make_seg(KIND_OTHER, px[0], py[0],
                                                           px[1], py[1]));
    if ($urandom_range(0, 3) == 0) segs.push_back(make_seg(kind_e'($urandom_range(0, 3)),
                                                           $urandom, $urandom,
                                                           $urandom, $urandom));
    for (int i = segs.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = segs[i];
      segs[i] = segs[j];
      segs[j] = tmp;
    end
    foreach (segs[i]) push(segs[i]);
    if ($urandom_range(0, 6) == 0) push(make_start($urandom, $urandom));
    else push(make_start(px[0], py[0]));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: forward link at the tolerance edge, reversed link with wrap, circle, other
    push(make_seg(KIND_LINE, 0, 0, 32'd100, 0));
    push(make_seg(KIND_OTHER, 32'd100, 0, 32'd5, 32'd5));
    push(make_seg(KIND_ARC, 32'd120, -32'sd20, 32'd300, 32'd300));
    push(make_seg(KIND_CIRCLE, 32'd7, 32'd7, 32'd9, 32'd9));
    tmp_rev_heading();
    push(make_seg(KIND_LINE, 32'd500, 32'd500, 32'd321, 32'd300));
    push(make_start(0, 0));
    push(make_start(0, 0));
    push(make_seg(KIND_CIRCLE, 0, 0, 0, 0));
    push(make_start(0, 0));

    // extremes with no tolerance
    set_tolerance(16'd0);
    push(make_seg(KIND_LINE, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    push(make_seg(KIND_ARC, 32'h80000000, 32'h80000001, 0, 0));
    push(make_start(32'h7fffffff, 32'h80000000));

    // widest tolerance, no wrap on far-apart extremes
    set_tolerance(16'hffff);
    push(make_seg(KIND_LINE, 32'h7fffffff, 32'h7fffffff, 32'h00010000, 0));
    push(make_seg(KIND_ARC, 32'h80000000, 0, 32'h00020001, 0));
    push(make_seg(KIND_LINE, 32'h0002ffff, 0, 32'h00100000, 0));
    push(make_start(32'h80000000, 32'h7fffffff));
    push(make_seg(KIND_LINE, 32'h7fff0000, 32'h7fffffff, 0, 0));
    push(make_start(32'h7fffffff, 32'h7fffffff));

    // full store with overflow loads dropped
    set_tolerance(TOL_RESET);
    quiet = 1'b1;
    chain_phase(66);
    quiet = 1'b0;

    while (sent < 150) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: set_tolerance(16'd0);
          1: set_tolerance(16'hffff);
          2: set_tolerance(TOL_RESET);
          default: set_tolerance(16'($urandom));
        endcase
      end
      quiet = ($urandom_range(0, 3) == 0);
      chain_phase(($urandom_range(0, 19) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 8));
    end

    quiet = 1'b0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  task automatic tmp_rev_heading();
    in_item_t it;
    it = make_seg(KIND_LINE, 32'd321, 32'd300, 32'd300, 32'd300);
    it.seg_heading = 25'd5898240;
    push(it);
    it = make_seg(KIND_ARC, 32'd900, 32'd900, 32'd321, 32'd300);
    it.seg_heading = 25'h1ffffff;
    push(it);
  endtask

endmodule
